// ----- design/rmkr_pkg.sv -----
// Shared types, constants and keyword tables of the RX message keyword recognizer.
package rmkr_pkg;

   localparam int MSG_SIZE_DEFAULT  = 64;
   localparam int NUM_KEYS          = 8;
   localparam int KEY_MAX_LEN       = 6;
   localparam int KEY_SETVT         = 6;
   localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'h2000;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic END_FULL    = 1'b0;
   localparam logic END_TIMEOUT = 1'b1;

   // Control from the message sequencer to every keyword matcher.
   typedef struct packed {
      logic       feed;   // a live text byte reaches the matchers
      logic       clear;  // the message ends, drop all progress
      logic [7:0] data;
   } match_ctl_type;

   // Status back from one matcher.
   typedef struct packed {
      logic found;  // keyword seen earlier in this message
      logic hit;    // keyword completes with the byte of this cycle
   } match_stat_type;

   // Keyword text, left-justified, zero-padded to six bytes.
   function automatic logic [47:0] key_text(input int k);
      logic [47:0] t;
      case (k)
         0:       t = {"OK", 32'h0};
         1:       t = {"bon", 24'h0};
         2:       t = {"boff", 16'h0};
         3:       t = {"rv", 32'h0};
         4:       t = {"rloc", 16'h0};
         5:       t = "setnr=";
         6:       t = "setvt=";
         7:       t = "$GPRMC";
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [2:0] key_len(input int k);
      logic [2:0] n;
      case (k)
         0:       n = 3'd2;
         1:       n = 3'd3;
         2:       n = 3'd4;
         3:       n = 3'd2;
         4:       n = 3'd4;
         5:       n = 3'd6;
         6:       n = 3'd6;
         7:       n = 3'd6;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

endpackage

// ----- design/rx_message_keyword_recognizer.sv -----
// Top level: input register, message sequencer, eight keyword matchers, result register.
//
//   channel  direction  ports                                    handshake
//   req      in         req_cmd, req_data_byte                   req_valid / req_ready
//   rsp      out        rsp_*_seen, rsp_threshold_byte,          rsp_valid / rsp_ready
//                       rsp_message_length, rsp_end_cause
//   csr      in         csr_write_data (idle_timeout)            csr_write_en, no wait
//
// One request per cycle sustained while no result waits; the result of a message that a
// request ends enters the result register as the request leaves the input register.
// Reset is synchronous, active high; it clears all message state and loads idle_timeout
// with 0x2000. When a result waits in the result register, the next request is held in
// the input register; req_ready stays high as long as that register can advance.
module rx_message_keyword_recognizer
   import rmkr_pkg::*;
#(
   parameter int MSG_SIZE = MSG_SIZE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok_seen,
   output logic        rsp_buzzer_on_seen,
   output logic        rsp_buzzer_off_seen,
   output logic        rsp_voltage_request_seen,
   output logic        rsp_location_request_seen,
   output logic        rsp_number_update_seen,
   output logic        rsp_threshold_update_seen,
   output logic        rsp_position_sentence_seen,
   output logic [7:0]  rsp_threshold_byte,
   output logic [6:0]  rsp_message_length,
   output logic        rsp_end_cause,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   localparam int CNT_W = $clog2(MSG_SIZE + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MSG_SIZE);

   // configuration
   logic [15:0] timeout_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_cmd_ff;
   logic [7:0]  s1_byte_ff;

   // message state
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      ticks_ff, ticks_in;
   logic             run_ff, run_in;
   logic             ended_ff, ended_in;
   logic             pending_ff, pending_in;
   logic [7:0]       cap_ff, cap_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NUM_KEYS-1:0] rsp_flags_ff;
   logic [7:0]       rsp_thr_ff;
   logic [6:0]       rsp_len_ff;
   logic             rsp_cause_ff;

   logic             advance;
   logic             is_byte;
   logic             live;
   logic             zero_byte;
   logic [CNT_W-1:0] cnt_inc;
   logic [16:0]      ticks_inc;
   logic [15:0]      tmo_eff;
   logic             full_done;
   logic             tick_done;
   logic             finish;
   logic [7:0]       cap_now;
   logic [NUM_KEYS-1:0] flags_now;
   logic [CNT_W+6:0] len_wide;
   match_ctl_type    mctl;
   match_stat_type   mstat [NUM_KEYS];

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         timeout_ff  <= IDLE_TIMEOUT_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_write_en) begin
            timeout_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff  <= req_cmd;
         s1_byte_ff <= req_data_byte;
      end
   end

   // sequencer: frame bytes into messages and decide when one ends
   always_comb begin
      is_byte   = (s1_cmd_ff == CMD_BYTE);
      live      = is_byte && !ended_ff;
      zero_byte = (s1_byte_ff == 8'd0);
      cnt_inc   = cnt_ff + CNT_W'(1);
      ticks_inc = {1'b0, ticks_ff} + 17'd1;
      tmo_eff   = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
      full_done = is_byte && (cnt_inc >= CNT_FULL);
      tick_done = (s1_cmd_ff == CMD_TICK) && run_ff && (ticks_inc >= {1'b0, tmo_eff});
      finish    = advance && (full_done || tick_done);

      mctl.feed  = advance && live && !zero_byte;
      mctl.clear = finish;
      mctl.data  = s1_byte_ff;

      for (int k = 0; k < NUM_KEYS; k++) begin
         flags_now[k] = mstat[k].found | mstat[k].hit;
      end

      // the byte right after setvt= is taken before the matchers see it
      cap_now = cap_ff;
      if (advance && live && pending_ff) begin
         cap_now = zero_byte ? 8'd0 : s1_byte_ff;
      end

      len_wide = {7'd0, (is_byte ? cnt_inc : cnt_ff)};
   end

   always_comb begin
      cnt_in     = cnt_ff;
      ticks_in   = ticks_ff;
      run_in     = run_ff;
      ended_in   = ended_ff;
      pending_in = pending_ff;
      cap_in     = cap_now;
      if (finish) begin
         cnt_in     = '0;
         ticks_in   = '0;
         run_in     = 1'b0;
         ended_in   = 1'b0;
         pending_in = 1'b0;
         cap_in     = '0;
      end else if (advance) begin
         if (is_byte) begin
            cnt_in   = cnt_inc;
            ticks_in = '0;
            run_in   = 1'b1;
            if (live) begin
               if (zero_byte) begin
                  ended_in = 1'b1;
               end
               pending_in = mstat[KEY_SETVT].hit;
            end
         end else if (run_ff) begin
            ticks_in = ticks_inc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         ticks_ff   <= '0;
         run_ff     <= 1'b0;
         ended_ff   <= 1'b0;
         pending_ff <= 1'b0;
         cap_ff     <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         ticks_ff   <= ticks_in;
         run_ff     <= run_in;
         ended_ff   <= ended_in;
         pending_ff <= pending_in;
         cap_ff     <= cap_in;
      end
   end

   for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
      rmkr_matcher #(
         .KEY(g)
      ) u_matcher (
         .clock(clock),
         .reset(reset),
         .ctl  (mctl),
         .stat (mstat[g])
      );
   end

   // result register
   assign rsp_valid_in = finish ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_flags_ff <= flags_now;
         rsp_thr_ff   <= cap_now;
         rsp_len_ff   <= len_wide[6:0];
         rsp_cause_ff <= tick_done ? END_TIMEOUT : END_FULL;
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_ok_seen                = rsp_flags_ff[0];
   assign rsp_buzzer_on_seen         = rsp_flags_ff[1];
   assign rsp_buzzer_off_seen        = rsp_flags_ff[2];
   assign rsp_voltage_request_seen   = rsp_flags_ff[3];
   assign rsp_location_request_seen  = rsp_flags_ff[4];
   assign rsp_number_update_seen     = rsp_flags_ff[5];
   assign rsp_threshold_update_seen  = rsp_flags_ff[6];
   assign rsp_position_sentence_seen = rsp_flags_ff[7];
   assign rsp_threshold_byte         = rsp_thr_ff;
   assign rsp_message_length         = rsp_len_ff;
   assign rsp_end_cause              = rsp_cause_ff;

   a_clear_on_finish: assert property (@(posedge clock) disable iff (reset)
      finish |=> (cnt_ff == '0) && !run_ff && !pending_ff)
      else $error("message state not cleared after a result");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_end_cause == END_FULL)) |-> (rsp_message_length == 7'(MSG_SIZE)))
      else $error("full message reports wrong length");

   a_no_feed_after_zero: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> !mctl.feed)
      else $error("matchers fed after end of text");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> (ticks_ff == 16'd0))
      else $error("idle ticks counted with no message in progress");

endmodule

// ----- design/rmkr_matcher.sv -----
// One keyword matcher: tracks the matched prefix length and the found flag.
module rmkr_matcher
   import rmkr_pkg::*;
#(
   parameter int KEY = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  match_ctl_type  ctl,
   output match_stat_type stat
);

   localparam logic [47:0] TXT   = key_text(KEY);
   localparam logic [2:0]  LEN   = key_len(KEY);
   localparam logic [7:0]  FIRST = TXT[47:40];

   logic [2:0]  prog_ff, prog_in;
   logic        found_ff, found_in;
   logic [47:0] txt_sh;
   logic        match;
   logic [2:0]  prog_adv;
   logic        hit;

   always_comb begin
      txt_sh   = TXT << {prog_ff, 3'b000};
      match    = (prog_ff < LEN) && (txt_sh[47:40] == ctl.data);
      // every keyword's first character is unique in it, so restart at 1 or 0
      prog_adv = match ? prog_ff + 3'd1 : ((ctl.data == FIRST) ? 3'd1 : 3'd0);
      hit      = ctl.feed && !found_ff && (prog_adv == LEN);
   end

   always_comb begin
      prog_in  = prog_ff;
      found_in = found_ff;
      if (ctl.clear) begin
         prog_in  = '0;
         found_in = 1'b0;
      end else if (ctl.feed && !found_ff) begin
         prog_in  = hit ? 3'd0 : prog_adv;
         found_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         prog_ff  <= prog_in;
         found_ff <= found_in;
      end
   end

   assign stat.found = found_ff;
   assign stat.hit   = hit;

endmodule

// ----- dv/tb_rx_message_keyword_recognizer.sv -----
// Testbench for the RX message keyword recognizer: random and directed requests checked against a model.
`timescale 1ns / 1ps

module tb_rx_message_keyword_recognizer;
   import rmkr_pkg::*;

   localparam int MSG_LEN = MSG_SIZE_DEFAULT;
   localparam int SETTLE_CYCLES = 6;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
   } rx_item_type;

   typedef struct packed {
      logic [7:0] flags;
      logic [7:0] thr;
      logic [6:0] len;
      logic       cause;
   } msg_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ok_seen;
   logic        rsp_buzzer_on_seen;
   logic        rsp_buzzer_off_seen;
   logic        rsp_voltage_request_seen;
   logic        rsp_location_request_seen;
   logic        rsp_number_update_seen;
   logic        rsp_threshold_update_seen;
   logic        rsp_position_sentence_seen;
   logic [7:0]  rsp_threshold_byte;
   logic [6:0]  rsp_message_length;
   logic        rsp_end_cause;
   logic        csr_write_en = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   rx_message_keyword_recognizer #(
      .MSG_SIZE(MSG_LEN)
   ) u_top (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_cmd                   (req_cmd),
      .req_data_byte             (req_data_byte),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_ok_seen               (rsp_ok_seen),
      .rsp_buzzer_on_seen        (rsp_buzzer_on_seen),
      .rsp_buzzer_off_seen       (rsp_buzzer_off_seen),
      .rsp_voltage_request_seen  (rsp_voltage_request_seen),
      .rsp_location_request_seen (rsp_location_request_seen),
      .rsp_number_update_seen    (rsp_number_update_seen),
      .rsp_threshold_update_seen (rsp_threshold_update_seen),
      .rsp_position_sentence_seen(rsp_position_sentence_seen),
      .rsp_threshold_byte        (rsp_threshold_byte),
      .rsp_message_length        (rsp_message_length),
      .rsp_end_cause             (rsp_end_cause),
      .csr_write_en              (csr_write_en),
      .csr_write_data            (csr_write_data)
   );

   always #5 clock = ~clock;

   string kw [8] = '{"OK", "bon", "boff", "rv", "rloc", "setnr=", "setvt=", "$GPRMC"};
   string flag_name [8] = '{"ok_seen", "buzzer_on_seen", "buzzer_off_seen",
                            "voltage_request_seen", "location_request_seen",
                            "number_update_seen", "threshold_update_seen",
                            "position_sentence_seen"};

   rx_item_type    rx_pending [$];
   msg_report_type reports [$];
   int             queued = 0;
   int             errors = 0;
   bit             steady = 1'b0;
   bit             req_taken = 1'b0;
   rx_item_type    next_req;
   msg_report_type want;
   msg_report_type seen;

   // Message tracker state
   logic [15:0] idle_limit = IDLE_TIMEOUT_RESET;
   int          msg_bytes = 0;
   int          quiet_ticks = 0;
   bit          msg_open = 1'b0;
   int          kw_pos [8] = '{default: 0};
   logic [7:0]  kw_found = 8'h00;
   bit          text_done = 1'b0;
   bit          thr_pending = 1'b0;
   logic [7:0]  thr_value = 8'h00;

   task automatic close_message(logic cause);
      reports.push_back(msg_report_type'{kw_found, thr_value, 7'(msg_bytes), cause});
      msg_bytes = 0;
      quiet_ticks = 0;
      msg_open = 1'b0;
      for (int k = 0; k < 8; k++) kw_pos[k] = 0;
      kw_found = 8'h00;
      text_done = 1'b0;
      thr_pending = 1'b0;
      thr_value = 8'h00;
   endtask

   task automatic scan_byte(logic [7:0] c);
      int p;
      if (text_done) return;
      if (c == 8'h00) begin
         // a zero byte ends the text; a pending threshold byte becomes zero
         text_done = 1'b1;
         if (thr_pending) begin
            thr_value = 8'h00;
            thr_pending = 1'b0;
         end
         return;
      end
      if (thr_pending) begin
         thr_value = c;
         thr_pending = 1'b0;
      end
      for (int k = 0; k < 8; k++) begin
         if (!kw_found[k]) begin
            p = kw_pos[k];
            if (p < kw[k].len() && 8'(kw[k][p]) == c) p++;
            else p = (8'(kw[k][0]) == c) ? 1 : 0;
            if (p >= kw[k].len()) begin
               kw_found[k] = 1'b1;
               p = 0;
               if (k == KEY_SETVT) thr_pending = 1'b1;
            end
            kw_pos[k] = p;
         end
      end
   endtask

   task automatic track_request(logic cmd, logic [7:0] c);
      if (cmd == CMD_BYTE) begin
         scan_byte(c);
         msg_bytes++;
         if (msg_bytes >= MSG_LEN) begin
            close_message(END_FULL);
         end else begin
            quiet_ticks = 0;
            msg_open = 1'b1;
         end
      end else if (msg_open) begin
         quiet_ticks++;
         // a limit of zero closes on the first tick, same as one
         if (quiet_ticks >= int'(idle_limit)) close_message(END_TIMEOUT);
      end
   endtask

   task automatic check_field(string what, int exp_v, int got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, got_v);
         errors++;
      end
   endtask

   // Driver: present the next pending request at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (rx_pending.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
            next_req = rx_pending.pop_front();
            req_valid <= 1'b1;
            req_cmd <= next_req.cmd;
            req_data_byte <= next_req.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && (steady || $urandom_range(99) >= 23);
   end

   // Monitor: track accepted requests, then check accepted results
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) track_request(req_cmd, req_data_byte);
         if (rsp_valid && rsp_ready) begin
            seen = msg_report_type'{{rsp_position_sentence_seen, rsp_threshold_update_seen,
                                     rsp_number_update_seen, rsp_location_request_seen,
                                     rsp_voltage_request_seen, rsp_buzzer_off_seen,
                                     rsp_buzzer_on_seen, rsp_ok_seen},
                                    rsp_threshold_byte, rsp_message_length, rsp_end_cause};
            if (reports.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %h", $time, seen);
               errors++;
            end else begin
               want = reports.pop_front();
               for (int k = 0; k < 8; k++)
                  check_field(flag_name[k], want.flags[k], seen.flags[k]);
               check_field("threshold_byte", want.thr, seen.thr);
               check_field("message_length", want.len, seen.len);
               check_field("end_cause", want.cause, seen.cause);
            end
         end
      end
   end

   task automatic queue_byte(logic [7:0] b);
      rx_pending.push_back(rx_item_type'{CMD_BYTE, b});
      queued++;
   endtask

   task automatic queue_ticks(int n);
      for (int i = 0; i < n; i++) begin
         rx_pending.push_back(rx_item_type'{CMD_TICK, 8'($urandom_range(255))});
         queued++;
      end
   endtask

   task automatic queue_text(string s);
      for (int i = 0; i < s.len(); i++) queue_byte(8'(s[i]));
   endtask

   // Bytes built from keywords, keyword prefixes and filler, closed by a timeout unless the buffer fills first
   task automatic queue_message(int target, int tmo);
      string pool;
      string word;
      int n;
      int pick;
      pool = "OKbonfrvlcsetn=$GPRM";
      n = 0;
      while (n < target) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            word = kw[$urandom_range(7)];
            if ($urandom_range(3) == 0) word = word.substr(0, $urandom_range(word.len() - 2));
            queue_text(word);
            n += word.len();
         end else begin
            if (pick < 45) queue_byte(8'h00);
            else if (pick < 75) queue_byte(8'(pool[$urandom_range(pool.len() - 1)]));
            else queue_byte(8'($urandom_range(255)));
            n++;
         end
         // a short silence that the next byte cuts off
         if (tmo >= 2 && $urandom_range(9) == 0) queue_ticks($urandom_range(1, tmo - 1));
      end
      queue_ticks(((tmo < 1) ? 1 : tmo) + $urandom_range(0, 2));
   endtask

   task automatic random_phase(int budget, int tmo);
      int start;
      start = queued;
      while (queued - start < budget) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(1)) queue_byte(8'($urandom_range(255)));
               else queue_ticks(1);
            end
         end else begin
            queue_message(($urandom_range(9) == 0) ? $urandom_range(55, 70)
                                                   : $urandom_range(1, 20), tmo);
         end
      end
   endtask

   task automatic drain();
      while (rx_pending.size() != 0 || req_valid || reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_timeout(logic [15:0] v);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_en <= 1'b0;
      idle_limit = v;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the reset limit outlasts a short silence; the zero limit below closes it
      queue_text("OK");
      queue_ticks(40);
      drain();

      // directed: zero limit, tick while idle, threshold capture corner cases
      set_timeout(16'h0000);
      queue_ticks(1);
      queue_ticks(1);
      queue_text("setvt=");
      queue_byte(8'hFF);
      queue_ticks(1);
      queue_text("setvt=");
      queue_ticks(1);
      queue_text("setvt=");
      queue_byte(8'h00);
      queue_text("OK");
      queue_ticks(1);
      queue_text("rv");
      queue_ticks(1);
      drain();

      set_timeout(16'h0001);
      steady = 1'b1;
      random_phase(230, 1);
      drain();
      steady = 1'b0;

      set_timeout(16'h0003);
      random_phase(230, 3);
      drain();

      set_timeout(16'($urandom_range(4, 12)));
      random_phase(230, int'(idle_limit));
      drain();

      // longest limit: a silence that does not end the message, then a full buffer
      set_timeout(16'hFFFF);
      queue_text("rloc");
      queue_ticks(40);
      for (int i = 4; i < MSG_LEN; i++) queue_byte(8'($urandom_range(255)));
      drain();

      set_timeout(16'h0002);
      random_phase(230, 2);
      drain();

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #300_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
